// File: design/linked_list_manager_unit_assert.svh
// assertion macros for the linked list manager
`ifndef LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
`define LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define LLM_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define LLM_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: design/llm_pkg.sv
// shared types and constants for the linked list manager
package llm_pkg;
    localparam int Nodes = 64;
    localparam int ValueBits = 32;
    localparam int IdxBits = $clog2(Nodes);
    localparam int PtrBits = IdxBits + 1;
    localparam logic [PtrBits-1:0] NullPtr = PtrBits'(Nodes);
    localparam logic [PtrBits-1:0] PtrOne  = PtrBits'(1);

    localparam logic [2:0] FUNC_INS_HEAD = 3'd0;
    localparam logic [2:0] FUNC_INS_TAIL = 3'd1;
    localparam logic [2:0] FUNC_INS_POS  = 3'd2;
    localparam logic [2:0] FUNC_DEL_HEAD = 3'd3;
    localparam logic [2:0] FUNC_DEL_TAIL = 3'd4;
    localparam logic [2:0] FUNC_DEL_POS  = 3'd5;
    localparam logic [2:0] FUNC_READ     = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_POS_LOW = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_BADPOS  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef struct packed {
        logic [2:0]                  func;
        logic signed [15:0]          position;
        logic signed [ValueBits-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]                  status;
        logic signed [ValueBits-1:0] item_value;
        logic [PtrBits-1:0]          item_count;
        logic                        last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load_cmd;       // capture command, current <= head
        logic step;           // current <= read link, counter++
        logic take;           // write value into free node, fetch its link
        logic free_adv;       // free head <= fetched link
        logic link_new_head;  // new node becomes head
        logic save_next;      // new node links to successor of current
        logic link_prev_new;  // current links to new node
        logic unlink_head;    // head node goes back to the free list
        logic rd_follow;      // fetch link of the node after current
        logic bypass;         // current links past the removed node
        logic free_node;      // removed node goes back to the free list
        logic emit_value;
        logic emit_status;
        logic last;
        logic [2:0] status;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [2:0]          func;
        logic                pos_low;
        logic                pos_over_ins;
        logic                pos_over_del;
        logic                pos_one;
        logic                empty;
        logic                single;
        logic                full;
        logic                walk_done;
        logic                read_done;
        logic                init_done;
    } t_sts;
endpackage

// File: design/llm_ram.sv
// generic single-write, single-read ram with registered read
module llm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/llm_datapath.sv
// pointer registers, node memories and result register
module llm_datapath import llm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_ctl    i_ctl,
    output t_sts    o_sts,
    output t_result o_result,
    output logic    o_strobe
);
    logic [PtrBits-1:0]   r_head, r_free, r_count, r_cur, r_new, r_walk, r_goal;
    logic [PtrBits-1:0]   n_head, n_free, n_count, n_cur, n_new, n_walk, n_goal;
    logic [IdxBits:0]     r_init, n_init;
    logic [ValueBits-1:0] r_value, n_value;
    logic [PtrBits-1:0]   link_rd;
    logic [ValueBits-1:0] val_rd;
    logic                 link_we;
    logic [IdxBits-1:0]   link_wa, link_ra;
    logic [PtrBits-1:0]   link_wd;
    logic                 init_busy;
    logic [16:0]          pos_ext, cnt_ext;

    assign init_busy = r_init < PtrBits'(Nodes);
    assign pos_ext = {i_cmd.position[15], i_cmd.position};
    assign cnt_ext = 17'(r_count);

    llm_ram #(.Width(PtrBits), .Depth(Nodes)) u_link (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_wa),
        .i_wdata(link_wd),
        .i_raddr(link_ra),
        .o_rdata(link_rd)
    );

    llm_ram #(.Width(ValueBits), .Depth(Nodes)) u_value (
        .i_clk  (i_clk),
        .i_we   (i_ctl.take),
        .i_waddr(r_free[IdxBits-1:0]),
        .i_wdata(r_value),
        .i_raddr(r_cur[IdxBits-1:0]),
        .o_rdata(val_rd)
    );

    // link memory port control
    always_comb begin
        link_we = 1'b0;
        link_wa = r_cur[IdxBits-1:0];
        link_wd = r_free;
        link_ra = r_cur[IdxBits-1:0];
        if (init_busy) begin
            link_we = 1'b1;
            link_wa = r_init[IdxBits-1:0];
            link_wd = r_init + PtrOne;
        end else if (i_ctl.take) begin
            // fetch the next free node while taking the current one
            link_ra = r_free[IdxBits-1:0];
        end else if (i_ctl.rd_follow) begin
            link_ra = link_rd[IdxBits-1:0];
        end else if (i_ctl.link_new_head) begin
            link_we = 1'b1;
            link_wa = r_new[IdxBits-1:0];
            link_wd = r_head;
        end else if (i_ctl.save_next) begin
            link_we = 1'b1;
            link_wa = r_new[IdxBits-1:0];
            link_wd = link_rd;
        end else if (i_ctl.link_prev_new) begin
            link_we = 1'b1;
            link_wd = r_new;
        end else if (i_ctl.unlink_head) begin
            link_we = 1'b1;
            link_wd = r_free;
        end else if (i_ctl.bypass) begin
            link_we = 1'b1;
            link_wd = link_rd;
        end else if (i_ctl.free_node) begin
            link_we = 1'b1;
            link_wa = r_new[IdxBits-1:0];
            link_wd = r_free;
        end
    end

    // next values of the pointer and walk registers
    always_comb begin
        n_head  = r_head;
        n_free  = r_free;
        n_count = r_count;
        n_cur   = r_cur;
        n_new   = r_new;
        n_walk  = r_walk;
        n_goal  = r_goal;
        n_value = r_value;
        n_init  = r_init;
        if (init_busy) begin
            n_init = r_init + PtrOne;
        end
        if (i_ctl.load_cmd) begin
            n_value = i_cmd.value;
            n_cur   = r_head;
            n_walk  = PtrOne;
            // node to stop at when walking
            case (i_cmd.func)
                FUNC_INS_TAIL: begin
                    n_goal = r_count;
                end
                FUNC_DEL_TAIL: begin
                    n_goal = r_count - PtrOne;
                end
                default: begin
                    n_goal = i_cmd.position[PtrBits-1:0] - PtrOne;
                end
            endcase
        end
        if (i_ctl.step) begin
            n_cur  = link_rd;
            n_walk = r_walk + PtrOne;
        end
        if (i_ctl.take) begin
            n_new = r_free;
        end
        if (i_ctl.rd_follow) begin
            n_new = link_rd;
        end
        if (i_ctl.free_adv) begin
            n_free = link_rd;
        end
        if (i_ctl.link_new_head) begin
            n_head  = r_new;
            n_count = r_count + PtrOne;
        end
        if (i_ctl.link_prev_new) begin
            n_count = r_count + PtrOne;
        end
        if (i_ctl.unlink_head) begin
            n_head  = link_rd;
            n_free  = r_cur;
            n_count = r_count - PtrOne;
        end
        if (i_ctl.free_node) begin
            n_free  = r_new;
            n_count = r_count - PtrOne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NullPtr;
            r_free   <= '0;
            r_count  <= '0;
            r_init   <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_free   <= n_free;
            r_count  <= n_count;
            r_init   <= n_init;
            o_strobe <= i_ctl.emit_value || i_ctl.emit_status;
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_new   <= n_new;
        r_walk  <= n_walk;
        r_goal  <= n_goal;
        r_value <= n_value;
        o_result.status     <= i_ctl.status;
        o_result.item_value <= i_ctl.emit_value ? signed'(val_rd) : '0;
        o_result.item_count <= r_count;
        o_result.last       <= i_ctl.last;
    end

    assign o_sts.func         = i_cmd.func;
    assign o_sts.pos_low      = pos_ext[16] || pos_ext == 17'd0;
    assign o_sts.pos_over_ins = !pos_ext[16] && pos_ext > cnt_ext + 17'd1;
    assign o_sts.pos_over_del = !pos_ext[16] && pos_ext > cnt_ext;
    assign o_sts.pos_one      = pos_ext == 17'd1;
    assign o_sts.empty        = r_count == '0;
    assign o_sts.single       = r_count == PtrOne;
    assign o_sts.full         = r_count >= PtrBits'(Nodes);
    assign o_sts.walk_done    = r_walk >= r_goal;
    assign o_sts.read_done    = r_walk >= r_count;
    assign o_sts.init_done    = !init_busy;
endmodule

// File: design/llm_ctrl.sv
// command sequencer for the linked list manager
module llm_ctrl import llm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy
);
    `include "linked_list_manager_unit_assert.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WALK  = 4'd1;
    localparam logic [3:0] S_STEP  = 4'd2;
    localparam logic [3:0] S_INS_A = 4'd3;
    localparam logic [3:0] S_INS_B = 4'd4;
    localparam logic [3:0] S_INS_C = 4'd5;
    localparam logic [3:0] S_INS_D = 4'd6;
    localparam logic [3:0] S_DEL_A = 4'd7;
    localparam logic [3:0] S_DEL_B = 4'd8;
    localparam logic [3:0] S_DEL_C = 4'd9;
    localparam logic [3:0] S_DEL_D = 4'd10;
    localparam logic [3:0] S_RD_A  = 4'd11;
    localparam logic [3:0] S_RD_B  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;
    localparam logic [3:0] S_INIT  = 4'd14;

    logic [3:0] r_state, n_state;
    logic [2:0] r_func, n_func;
    logic       r_at_head, n_at_head;

    assign o_busy = r_state != S_IDLE;

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_at_head = r_at_head;
        o_ctl     = '0;
        case (r_state)
            S_INIT: begin
                if (i_sts.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load_cmd = 1'b1;
                    n_func = i_sts.func;
                    o_ctl.last = 1'b1;
                    case (i_sts.func)
                        FUNC_INS_HEAD, FUNC_INS_TAIL, FUNC_INS_POS: begin
                            if (i_sts.func == FUNC_INS_POS && i_sts.pos_low) begin
                                o_ctl.status = ST_POS_LOW; o_ctl.emit_status = 1'b1;
                            end else if (i_sts.func == FUNC_INS_POS && i_sts.pos_over_ins) begin
                                o_ctl.status = ST_RANGE; o_ctl.emit_status = 1'b1;
                            end else if (i_sts.full) begin
                                o_ctl.status = ST_FULL; o_ctl.emit_status = 1'b1;
                            end else begin
                                n_at_head = i_sts.func == FUNC_INS_HEAD || i_sts.empty ||
                                    (i_sts.func == FUNC_INS_POS && i_sts.pos_one);
                                n_state = n_at_head ? S_INS_A : S_WALK;
                            end
                        end
                        FUNC_DEL_HEAD, FUNC_DEL_TAIL: begin
                            if (i_sts.empty) begin
                                o_ctl.status = ST_EMPTY; o_ctl.emit_status = 1'b1;
                            end else begin
                                n_at_head = i_sts.func == FUNC_DEL_HEAD || i_sts.single;
                                n_state = n_at_head ? S_DEL_A : S_WALK;
                            end
                        end
                        FUNC_DEL_POS: begin
                            if (i_sts.pos_low || i_sts.empty) begin
                                o_ctl.status = ST_BADPOS; o_ctl.emit_status = 1'b1;
                            end else if (i_sts.pos_over_del) begin
                                o_ctl.status = ST_RANGE; o_ctl.emit_status = 1'b1;
                            end else begin
                                n_at_head = i_sts.pos_one;
                                n_state = n_at_head ? S_DEL_A : S_WALK;
                            end
                        end
                        FUNC_READ: begin
                            if (i_sts.empty) begin
                                o_ctl.status = ST_EMPTY; o_ctl.emit_status = 1'b1;
                            end else begin
                                n_state = S_RD_A;
                            end
                        end
                        default: begin
                            o_ctl.last = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // link of current node is read here, on the port next cycle
                if (i_sts.walk_done) begin
                    n_state = (r_func == FUNC_INS_TAIL || r_func == FUNC_INS_POS) ?
                              S_INS_A : S_DEL_A;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_ctl.step = 1'b1;
                n_state = S_WALK;
            end
            S_INS_A: begin
                o_ctl.take = 1'b1;
                n_state = S_INS_B;
            end
            S_INS_B: begin
                o_ctl.free_adv = 1'b1;
                if (r_at_head) begin
                    o_ctl.link_new_head = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS_C;
                end
            end
            S_INS_C: begin
                o_ctl.save_next = 1'b1;
                n_state = S_INS_D;
            end
            S_INS_D: begin
                o_ctl.link_prev_new = 1'b1;
                n_state = S_DONE;
            end
            S_DEL_A: begin
                n_state = S_DEL_B;
            end
            S_DEL_B: begin
                if (r_at_head) begin
                    o_ctl.unlink_head = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_ctl.rd_follow = 1'b1;
                    n_state = S_DEL_C;
                end
            end
            S_DEL_C: begin
                o_ctl.bypass = 1'b1;
                n_state = S_DEL_D;
            end
            S_DEL_D: begin
                o_ctl.free_node = 1'b1;
                n_state = S_DONE;
            end
            S_RD_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                o_ctl.emit_value = 1'b1;
                o_ctl.status = ST_OK;
                o_ctl.last = i_sts.read_done;
                if (i_sts.read_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctl.step = 1'b1;
                    n_state = S_RD_A;
                end
            end
            S_DONE: begin
                o_ctl.status = ST_OK;
                o_ctl.emit_status = 1'b1;
                o_ctl.last = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_func    <= FUNC_INS_HEAD;
            r_at_head <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_func    <= n_func;
            r_at_head <= n_at_head;
        end
    end

    `LLM_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, o_ctl.load_cmd, r_state == S_IDLE)
    `LLM_ASSERT_IMP(a_one_emit, i_clk, i_rst_n, 1'b1, !(o_ctl.emit_value && o_ctl.emit_status))
    `LLM_ASSERT_NXT(a_take_links, i_clk, i_rst_n, o_ctl.take, r_state == S_INS_B)
endmodule

// File: design/linked_list_manager_unit.sv
// top level of the linked list manager
// one command is taken while busy is low; every command but read-out gives one
// transaction on o_result, marked by o_strobe for a single cycle, and a read-out
// gives one transaction per stored value with last on the final one. the receiver
// cannot stall. rejected commands give their status the cycle after acceptance
// and keep busy low; an unused code gives nothing. head inserts run through
// S_INS_A, S_INS_B and S_DONE, head deletes through S_DEL_A, S_DEL_B and S_DONE,
// and the result is registered from S_DONE. tail and positional commands walk the
// link memory node by node, alternating S_WALK and S_STEP. a read-out alternates
// S_RD_A and S_RD_B, emitting a value from S_RD_B. after reset the link memory is
// chained as a free list, and busy stays high until that is done.
module linked_list_manager_unit import llm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result
);
    t_ctl ctl;
    t_sts sts;

    // sequencer
    llm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_ctl  (ctl),
        .o_busy (busy)
    );

    // memories and pointers
    llm_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );
endmodule
